FILE: src/gba_pkg.sv
// ----------------------------------------------------------------------------
// gba_pkg
// shared widths and types for the group break average block
// ----------------------------------------------------------------------------
package gba_pkg;

   localparam int KEY_BITS_DEF   = 20;
   localparam int GRADE_BITS_DEF = 8;
   localparam int COUNT_BITS_DEF = 16;

   // status of the serial divider as seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } gba_div_stat_type;

endpackage

FILE: src/gba_req_if.sv
// ----------------------------------------------------------------------------
// gba_req_if
// record channel: key, grade and end-of-stream flag with valid/ready
// ----------------------------------------------------------------------------
interface gba_req_if #(
   parameter int KEY_BITS   = gba_pkg::KEY_BITS_DEF,
   parameter int GRADE_BITS = gba_pkg::GRADE_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [KEY_BITS-1:0]   student_key;
   logic [GRADE_BITS-1:0] grade;
   logic                  stream_end;

   modport source (output valid, output student_key, output grade, output stream_end,
                   input ready);
   modport sink   (input valid, input student_key, input grade, input stream_end,
                   output ready);
endinterface

FILE: src/gba_rsp_if.sv
// ----------------------------------------------------------------------------
// gba_rsp_if
// group result channel: key, average and flags with valid/ready
// ----------------------------------------------------------------------------
interface gba_rsp_if #(
   parameter int KEY_BITS   = gba_pkg::KEY_BITS_DEF,
   parameter int GRADE_BITS = gba_pkg::GRADE_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [KEY_BITS-1:0]   group_key;
   logic [GRADE_BITS-1:0] group_average;
   logic                  group_overflow;
   logic                  run_last;

   modport source (output valid, output group_key, output group_average,
                   output group_overflow, output run_last, input ready);
   modport sink   (input valid, input group_key, input group_average,
                   input group_overflow, input run_last, output ready);
endinterface

FILE: src/gba_divider.sv
// ----------------------------------------------------------------------------
// gba_divider
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gba_divider #(
   parameter int SUM_BITS   = gba_pkg::GRADE_BITS_DEF + gba_pkg::COUNT_BITS_DEF,
   parameter int COUNT_BITS = gba_pkg::COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [SUM_BITS-1:0]      dividend,
   input  logic [COUNT_BITS-1:0]    divisor,
   output logic [SUM_BITS-1:0]      quotient,
   output gba_pkg::gba_div_stat_type stat
);
   import gba_pkg::*;

   localparam int CNT_W = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;

   logic [SUM_BITS-1:0]   quo_ff, quo_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] den_ff, den_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [COUNT_BITS:0]   shifted;
   logic [COUNT_BITS+1:0] diff;

   // shift in the next dividend bit and try to subtract
   assign shifted = {rem_ff, quo_ff[SUM_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[COUNT_BITS+1]) begin
            rem_in = shifted[COUNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end else begin
            rem_in = diff[COUNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(SUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: src/group_break_average.sv
// ----------------------------------------------------------------------------
// group_break_average
// control-break grouping of a key-sorted record stream with per-group average
// ----------------------------------------------------------------------------
// Records (student_key, grade, stream_end) arrive sorted by key. Consecutive
// records with one key form a group; the block keeps its key, grade sum and
// record count. A record with a different key closes the open group and
// delivers its key and truncated average sum/count; a record marked stream_end
// also closes its own group, so such a record can cause two items, the old
// group first. run_last marks the final item caused by a record. Past the
// count range, further records of a group only set group_overflow and the
// average stays that of the counted records. A record that closes nothing
// only updates the open group; each delivered item is loaded into the
// divider, runs through the serial restoring divider, has its quotient
// captured, and then waits in the output register until taken. The block
// does not take a record while an item is being computed or waits on the
// output.
// ----------------------------------------------------------------------------
module group_break_average #(
   parameter int KEY_BITS   = gba_pkg::KEY_BITS_DEF,
   parameter int GRADE_BITS = gba_pkg::GRADE_BITS_DEF,
   parameter int COUNT_BITS = gba_pkg::COUNT_BITS_DEF
) (
   input logic     clock,
   input logic     reset,
   gba_req_if.sink   req,
   gba_rsp_if.source rsp
);
   import gba_pkg::*;

   localparam int SUM_BITS = GRADE_BITS + COUNT_BITS;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;

   // open group
   logic                  open_ff, open_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  ovf_ff, ovf_in;

   // item being computed / held for delivery
   logic                  pend_end_ff, pend_end_in;
   logic [KEY_BITS-1:0]   out_key_ff, out_key_in;
   logic [GRADE_BITS-1:0] out_avg_ff, out_avg_in;
   logic                  out_ovf_ff, out_ovf_in;
   logic                  out_last_ff, out_last_in;

   // divider hookup
   logic                  div_start;
   logic [SUM_BITS-1:0]   div_dividend;
   logic [COUNT_BITS-1:0] div_divisor;
   logic [SUM_BITS-1:0]   div_quotient;
   gba_div_stat_type      div_stat;

   // record decode
   logic                  req_fire;
   logic                  rsp_fire;
   logic                  key_change;
   logic                  count_full;
   logic [KEY_BITS-1:0]   upd_key;
   logic [SUM_BITS-1:0]   upd_sum;
   logic [COUNT_BITS-1:0] upd_count;
   logic                  upd_ovf;

   assign req_fire   = req.valid && req.ready;
   assign rsp_fire   = rsp.valid && rsp.ready;
   assign key_change = open_ff && (req.student_key != key_ff);
   assign count_full = (count_ff == {COUNT_BITS{1'b1}});

   // group contents after this record, when it does not close the group
   always_comb begin
      upd_key   = key_ff;
      upd_sum   = sum_ff;
      upd_count = count_ff;
      upd_ovf   = ovf_ff;
      if (!open_ff || key_change) begin
         upd_key   = req.student_key;
         upd_sum   = SUM_BITS'(req.grade);
         upd_count = COUNT_BITS'(1);
         upd_ovf   = 1'b0;
      end else if (count_full) begin
         upd_ovf   = 1'b1;
      end else begin
         upd_sum   = sum_ff + SUM_BITS'(req.grade);
         upd_count = count_ff + COUNT_BITS'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      key_in       = key_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      pend_end_in  = pend_end_ff;
      out_key_in   = out_key_ff;
      out_avg_in   = out_avg_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      div_start    = 1'b0;
      div_dividend = sum_ff;
      div_divisor  = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (key_change) begin
                  // close the old group now, the record opens a new one
                  div_start   = 1'b1;
                  out_key_in  = key_ff;
                  out_ovf_in  = ovf_ff;
                  out_last_in = !req.stream_end;
                  pend_end_in = req.stream_end;
                  state_in    = ST_DIV;
                  open_in     = 1'b1;
                  key_in      = upd_key;
                  sum_in      = upd_sum;
                  count_in    = upd_count;
                  ovf_in      = upd_ovf;
               end else if (req.stream_end) begin
                  // end record inside its group: flush updated group, go empty
                  div_start    = 1'b1;
                  div_dividend = upd_sum;
                  div_divisor  = upd_count;
                  out_key_in   = upd_key;
                  out_ovf_in   = upd_ovf;
                  out_last_in  = 1'b1;
                  pend_end_in  = 1'b0;
                  state_in     = ST_DIV;
                  open_in      = 1'b0;
                  key_in       = '0;
                  sum_in       = '0;
                  count_in     = '0;
                  ovf_in       = 1'b0;
               end else begin
                  open_in  = 1'b1;
                  key_in   = upd_key;
                  sum_in   = upd_sum;
                  count_in = upd_count;
                  ovf_in   = upd_ovf;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               out_avg_in = div_quotient[GRADE_BITS-1:0];
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (pend_end_ff) begin
                  // second item of a key change on an end record
                  div_start   = 1'b1;
                  out_key_in  = key_ff;
                  out_ovf_in  = ovf_ff;
                  out_last_in = 1'b1;
                  pend_end_in = 1'b0;
                  state_in    = ST_DIV;
                  open_in     = 1'b0;
                  key_in      = '0;
                  sum_in      = '0;
                  count_in    = '0;
                  ovf_in      = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      out_key_ff  <= out_key_in;
      out_avg_ff  <= out_avg_in;
      out_ovf_ff  <= out_ovf_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         open_ff     <= 1'b0;
         key_ff      <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         pend_end_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         open_ff     <= open_in;
         key_ff      <= key_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         pend_end_ff <= pend_end_in;
      end
   end

   gba_divider #(
      .SUM_BITS   (SUM_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   // channel drive
   assign req.ready          = (state_ff == ST_IDLE);
   assign rsp.valid          = (state_ff == ST_OUT);
   assign rsp.group_key      = out_key_ff;
   assign rsp.group_average  = out_avg_ff;
   assign rsp.group_overflow = out_ovf_ff;
   assign rsp.run_last       = out_last_ff;

   // records are never taken while an item is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("record accepted while an item is pending");

   // divider finishes only while the sequencer waits on it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider done outside of the divide state");

   // an item that is not the last one always has a second one queued
   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.run_last) |-> pend_end_ff)
      else $error("non-last item without a pending end group");

   // after the last item of an end record no group stays open
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp.run_last && !pend_end_ff && out_last_ff && !open_ff)
      |=> !open_ff)
      else $error("group open after end of stream");

endmodule

FILE: bench/tb_group_break_average.sv
// ----------------------------------------------------------------------------
// tb_group_break_average
// self-checking bench for the group break average block
// ----------------------------------------------------------------------------
// Records go in on the req channel and group items come back on the rsp
// channel. A scoreboard keeps its own copy of the open group and predicts
// each closed group's key, truncated average, overflow flag and run_last
// marker. Each accepted item is checked in order against that prediction.
// The stimulus is a short directed set, then random key-sorted streams with
// occasional unsorted jumps and extreme keys. Both sides idle at random, and
// the receiver once holds off long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_group_break_average;
   import gba_pkg::*;

   localparam int KEY_W            = KEY_BITS_DEF;
   localparam int GRADE_W          = GRADE_BITS_DEF;
   localparam int COUNT_W          = COUNT_BITS_DEF;
   localparam int SUM_W            = GRADE_W + COUNT_W;
   localparam int COUNT_MAX        = (1 << COUNT_W) - 1;
   localparam int RANDOM_RECORDS   = 1050;
   localparam int MAX_GAP          = 18;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int HOLD_AT_ITEM     = 150;
   // divider load + serial steps + capture, plus a receiver stall, with margin
   localparam int TAIL_CYCLES      = 4 * (SUM_W + 2 + MAX_GAP);
   localparam longint LIMIT_TIME   = 64'd15_000_000;

   typedef struct packed {
      logic [KEY_W-1:0]   group_key;
      logic [GRADE_W-1:0] group_average;
      logic               group_overflow;
      logic               run_last;
   } group_result_type;

   // ------------------------------------------------------------------------
   // scoreboard: tracks the open group and holds the groups still to come
   // ------------------------------------------------------------------------
   class group_average_scoreboard;
      bit                 group_open;
      bit [KEY_W-1:0]     open_key;
      bit [SUM_W-1:0]     grade_sum;
      bit [COUNT_W-1:0]   record_count;
      bit                 count_saturated;
      group_result_type   pending_groups[$];
      int                 errors;
      int                 records_noted;
      int                 groups_checked;
      int                 overflow_groups;
      int                 double_closes;

      function group_result_type close_group(bit last_item);
         group_result_type r;
         r.group_key      = open_key;
         r.group_average  = GRADE_W'(grade_sum / record_count);
         r.group_overflow = count_saturated;
         r.run_last       = last_item;
         if (count_saturated) overflow_groups++;
         return r;
      endfunction

      function void open_group(bit [KEY_W-1:0] key, bit [GRADE_W-1:0] grade);
         group_open      = 1'b1;
         open_key        = key;
         grade_sum       = SUM_W'(grade);
         record_count    = 1;
         count_saturated = 1'b0;
      endfunction

      // accepted record: update the open group, queue any groups it closes
      function void note_record(bit [KEY_W-1:0] key, bit [GRADE_W-1:0] grade,
                                bit stream_end);
         int closed;
         closed = 0;
         records_noted++;
         if (!group_open) begin
            open_group(key, grade);
         end else if (key != open_key) begin
            pending_groups.push_back(close_group(!stream_end));
            closed++;
            open_group(key, grade);
         end else if (record_count == COUNT_W'(COUNT_MAX)) begin
            count_saturated = 1'b1;
         end else begin
            grade_sum    = grade_sum + SUM_W'(grade);
            record_count = record_count + 1'b1;
         end
         if (stream_end) begin
            pending_groups.push_back(close_group(1'b1));
            closed++;
            group_open      = 1'b0;
            open_key        = '0;
            grade_sum       = '0;
            record_count    = '0;
            count_saturated = 1'b0;
         end
         if (closed == 2) double_closes++;
      endfunction

      // accepted item: compare with the oldest pending group
      function void check_group(group_result_type got);
         group_result_type want;
         groups_checked++;
         if (pending_groups.size() == 0) begin
            errors++;
            $display("%0t: item with none expected: key %h average %0d overflow %b last %b",
                     $time, got.group_key, got.group_average, got.group_overflow,
                     got.run_last);
            return;
         end
         want = pending_groups.pop_front();
         if (got.group_key !== want.group_key) begin
            errors++;
            $display("%0t: group_key expected %h actual %h",
                     $time, want.group_key, got.group_key);
         end
         if (got.group_average !== want.group_average) begin
            errors++;
            $display("%0t: group_average expected %0d actual %0d (key %h)",
                     $time, want.group_average, got.group_average, want.group_key);
         end
         if (got.group_overflow !== want.group_overflow) begin
            errors++;
            $display("%0t: group_overflow expected %b actual %b (key %h)",
                     $time, want.group_overflow, got.group_overflow, want.group_key);
         end
         if (got.run_last !== want.run_last) begin
            errors++;
            $display("%0t: run_last expected %b actual %b (key %h)",
                     $time, want.run_last, got.run_last, want.group_key);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   gba_req_if req_ch ();
   gba_rsp_if rsp_ch ();

   group_break_average dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   group_average_scoreboard scoreboard = new;
   int longest_hold = 0;

   // 10 unit clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // idle cycles before an item, none in a calm stretch
   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // grades lean on the extremes
   function automatic logic [GRADE_W-1:0] draw_grade();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return GRADE_W'($urandom());
      endcase
   endfunction

   // offer one record after a gap, hold it until taken
   task automatic offer_record(input logic [KEY_W-1:0] key,
                               input logic [GRADE_W-1:0] grade,
                               input logic stream_end, input int gap);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.student_key = key;
      req_ch.grade       = grade;
      req_ch.stream_end  = stream_end;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      scoreboard.note_record(key, grade, stream_end);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side: random stalls, calm stretches and one long hold-off
   // ------------------------------------------------------------------------
   initial begin : result_sink
      int               stall;
      int               taken;
      bit               calm;
      group_result_type got;
      taken = 0;
      calm  = 1'b0;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         // switch between calm and stalling every few dozen items
         if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         stall = calm ? 0 : $urandom_range(0, MAX_GAP);
         // long hold so the output backs up and the input stalls
         if (taken == HOLD_AT_ITEM) stall = LONG_HOLD_CYCLES;
         if (stall > longest_hold) longest_hold = stall;
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got = '{rsp_ch.group_key, rsp_ch.group_average, rsp_ch.group_overflow,
                 rsp_ch.run_last};
         scoreboard.check_group(got);
         taken++;
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // record side
   // ------------------------------------------------------------------------
   initial begin : record_source
      logic [KEY_W-1:0] key;
      int               groups;
      int               group_len;
      int               random_sent;
      bit               calm;
      bit               stream_end;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.student_key = '0;
      req_ch.grade       = '0;
      req_ch.stream_end  = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // end record with no open group, on key zero and on the top key
      offer_record('0, '0, 1'b1, draw_gap(1'b0));
      offer_record('1, '1, 1'b1, draw_gap(1'b0));
      // plain group closed by a key change, then a two record group
      offer_record(KEY_W'(5), 8'd10, 1'b0, draw_gap(1'b0));
      offer_record(KEY_W'(5), 8'd11, 1'b0, draw_gap(1'b0));
      offer_record(KEY_W'(5), 8'd12, 1'b0, draw_gap(1'b0));
      offer_record(KEY_W'(9), 8'd255, 1'b0, draw_gap(1'b0));
      offer_record(KEY_W'(9), 8'd0, 1'b1, draw_gap(1'b0));
      // key change on an end record: old group then the end record's group
      offer_record(KEY_W'(20), 8'd1, 1'b0, draw_gap(1'b0));
      offer_record(KEY_W'(30), 8'd200, 1'b1, draw_gap(1'b0));
      // unsorted keys: a key seen again later is a new group
      offer_record(KEY_W'(100), 8'd7, 1'b0, draw_gap(1'b0));
      offer_record(KEY_W'(50), 8'd9, 1'b0, draw_gap(1'b0));
      offer_record(KEY_W'(100), 8'd3, 1'b1, draw_gap(1'b0));
      // top key group with full grades, then key zero with a full and a zero grade
      offer_record('1, '1, 1'b0, draw_gap(1'b0));
      offer_record('1, '1, 1'b0, draw_gap(1'b0));
      offer_record('0, '1, 1'b0, draw_gap(1'b0));
      offer_record('0, '0, 1'b1, draw_gap(1'b0));

      // random streams: mostly sorted groups, each stream ends on an end record
      random_sent = 0;
      while (random_sent < RANDOM_RECORDS) begin
         calm   = ($urandom_range(0, 4) == 0);
         key    = KEY_W'($urandom());
         groups = $urandom_range(1, 10);
         for (int g = 0; g < groups; g++) begin
            group_len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 14)
                                                    : $urandom_range(1, 4);
            for (int r = 0; r < group_len; r++) begin
               stream_end = (g == groups - 1) && (r == group_len - 1);
               offer_record(key, draw_grade(), stream_end, draw_gap(calm));
               random_sent++;
            end
            // next key: usually higher, sometimes a step back or an extreme
            case ($urandom_range(0, 9))
               0: key = key - KEY_W'($urandom_range(1, 1000));
               1: key = $urandom_range(0, 1) ? {KEY_W{1'b0}} : {KEY_W{1'b1}};
               default: key = key + KEY_W'($urandom_range(1, 5000));
            endcase
         end
      end
      req_ch.valid = 1'b0;

      // drain, then give a stray item time to show up
      while (scoreboard.pending_groups.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d records, checked %0d group items, %0d of them past the count limit",
               scoreboard.records_noted, scoreboard.groups_checked,
               scoreboard.overflow_groups);
      $display("%0d records closed two groups, longest output hold %0d cycles",
               scoreboard.double_closes, longest_hold);
      if (scoreboard.errors == 0) begin
         $display("group_break_average: match");
      end else begin
         $display("group_break_average: mismatch");
      end
      $finish;
   end

   // hang guard
   initial begin : run_limit
      #(LIMIT_TIME);
      $display("timeout at %0t", $time);
      $display("group_break_average: mismatch");
      $finish;
   end

endmodule

FILE: group_break_average.f
src/gba_pkg.sv
src/gba_req_if.sv
src/gba_rsp_if.sv
src/gba_divider.sv
src/group_break_average.sv
bench/tb_group_break_average.sv
